@@ hdl/tcce_pkg.sv @@
`timescale 1ns / 1ps
// tcce_pkg: shared types, codes and constants of the text console character engine
// no dependencies; imported by tcce_ctrl, tcce_datapath and the top level

package tcce_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int ADDR_W = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // tab stops every TAB_STEP columns
    localparam int TAB_STEP = 4;
    localparam int TAB_BITS = $clog2(TAB_STEP);

    // character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [15:0] BLANK_RESET = 16'h0720;
    localparam logic [7:0]  COLOR_RESET = 8'h07;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
        logic        did_scroll;
    } t_out_item;

    // class of an incoming request
    typedef enum logic [2:0] {
        K_READ,
        K_NOP,
        K_GLYPH,
        K_NEWLINE,
        K_BACK,
        K_TAB
    } t_kind;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_GLYPH,
        OP_NEWLINE,
        OP_SCROLL,
        OP_CLEAR,
        OP_BS_START,
        OP_BS_READ,
        OP_BS_STEP,
        OP_BLANK
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  col_last;
        logic  col_zero;
        logic  row_zero;
        logic  row_last;
        logic  is_tab;
        logic  tab_stop;
        logic  left_space;
        logic  move_done;
        logic  cnt_last;
        logic  out_free;
    } t_dp_status;

endpackage

@@ hdl/text_console_character_engine_core.sv @@
`timescale 1ns / 1ps
// a read or NUL goes straight to the result and a glyph is written at the cursor;
// a tab writes spaces up to the next tab stop; a backspace that climbs a row skips
// trailing spaces; a line wrap sends a glyph or tab on through a newline, and a
// newline on the last row scrolls: the row move, then the last-row clear (one write a cycle)
// throughput: one item at a time, the next taken in the cycle the result is registered
// reset (i_rst_n low, synchronous): cursor 0, colour 7, then a store sweep over all
// ROWS*COLUMNS cells with no item taken; config writes are accepted throughout the sweep

module text_console_character_engine_core #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcce_pkg::t_in_item  i_in_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcce_pkg::t_out_item o_out_item,
    // text colour register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import tcce_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: decides which store operation runs each cycle and when
    // an item may enter; it sees only status flags, never the payload
    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: screen store with one write and one registered read port,
    // cursor registers, colour register and the result register that
    // decouples the result channel from the request channel
    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ hdl/tcce_ctrl.sv @@
`timescale 1ns / 1ps
// tcce_ctrl: sequencing state machine of the character engine
// depends on tcce_pkg; drives tcce_datapath through t_dp_cmd

module tcce_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tcce_pkg::t_dp_status i_status,
    output tcce_pkg::t_dp_cmd    o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_GLYPH   = 11'b000_0000_0100,
        S_NEWLINE = 11'b000_0000_1000,
        S_SCROLL  = 11'b000_0001_0000,
        S_SCLEAR  = 11'b000_0010_0000,
        S_BACK    = 11'b000_0100_0000,
        S_BS_RD   = 11'b000_1000_0000,
        S_BS_CHK  = 11'b001_0000_0000,
        S_BS_WR   = 11'b010_0000_0000,
        S_FINISH  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    function automatic t_state dispatch(input t_kind kind);
        t_state s;
        unique case (kind)
            K_READ, K_NOP:  s = S_FINISH;
            K_GLYPH, K_TAB: s = S_GLYPH;
            K_NEWLINE:      s = S_NEWLINE;
            K_BACK:         s = S_BACK;
            default:        s = S_FINISH;
        endcase
        return s;
    endfunction

    always_comb begin
        n_state    = r_state;
        o_cmd      = '{op: OP_NONE, accept: 1'b0, load_out: 1'b0};
        o_in_stall = 1'b1;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = dispatch(i_status.in_kind);
                end
            end
            S_GLYPH: begin
                o_cmd.op = OP_GLYPH;
                if (i_status.col_last) begin
                    n_state = S_NEWLINE;
                end else if (!(i_status.is_tab && !i_status.tab_stop)) begin
                    n_state = S_FINISH;
                end
            end
            S_NEWLINE: begin
                o_cmd.op = OP_NEWLINE;
                n_state  = i_status.row_last ? S_SCROLL : S_FINISH;
            end
            S_SCROLL: begin
                o_cmd.op = OP_SCROLL;
                if (i_status.move_done) begin
                    n_state = S_SCLEAR;
                end
            end
            S_SCLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.cnt_last) begin
                    n_state = S_FINISH;
                end
            end
            S_BACK: begin
                o_cmd.op = OP_BS_START;
                n_state  = (i_status.col_zero && !i_status.row_zero) ? S_BS_RD : S_BS_WR;
            end
            S_BS_RD: begin
                if (i_status.col_zero) begin
                    n_state = S_BS_WR;
                end else begin
                    o_cmd.op = OP_BS_READ;
                    n_state  = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                o_cmd.op = OP_BS_STEP;
                n_state  = i_status.left_space ? S_BS_RD : S_BS_WR;
            end
            S_BS_WR: begin
                o_cmd.op = OP_BLANK;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_stall     = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = dispatch(i_status.in_kind);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // items only enter between requests
    a_accept_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> (r_state == S_IDLE || r_state == S_FINISH))
        else $error("item taken while a request is in progress");

    // a completed scroll move is always followed by the last-row clear
    a_scroll_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && i_status.move_done) |=> (r_state == S_SCLEAR))
        else $error("scroll move not followed by row clear");

endmodule

@@ hdl/tcce_datapath.sv @@
`timescale 1ns / 1ps
// tcce_datapath: screen store, cursor, colour register and result register
// depends on tcce_pkg; commanded by tcce_ctrl

module tcce_datapath #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcce_pkg::t_in_item   i_in_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data,
    input  tcce_pkg::t_dp_cmd    i_cmd,
    output tcce_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output tcce_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall
);
    import tcce_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int MOVE  = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
    localparam logic [AW-1:0] MOVE_A = AW'(MOVE);
    localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    logic [15:0]   mem [CELLS];
    logic [15:0]   r_rd_data;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_cnt;
    logic [7:0]    r_text_color;
    logic [7:0]    r_char;
    logic          r_req_read;
    logic          r_addr_ok;
    logic          r_scrolled;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic [AW-1:0] pos;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] in_addr_ext;
    logic          in_addr_ok;
    logic [CW:0]   col_inc;
    logic [7:0]    glyph_ch;
    logic          is_tab;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_kind         in_kind;
    t_out_item     out_next;

    assign pos         = AW'(r_row) * COLS_A + AW'(r_col);
    assign pos_ext     = PW'(pos);
    assign in_addr_ext = PW'(i_in_item.cell_address);
    assign in_addr_ok  = in_addr_ext < PW'(CELLS);
    assign col_inc     = (CW + 1)'(r_col) + 1'b1;
    assign is_tab      = (r_char == CH_TAB);
    assign glyph_ch    = is_tab ? CH_SPACE : r_char;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_in_item.req_type == REQ_READ) begin
            in_kind = K_READ;
        end else if (i_in_item.char_code == CH_NL) begin
            in_kind = K_NEWLINE;
        end else if (i_in_item.char_code == CH_BS) begin
            in_kind = K_BACK;
        end else if (i_in_item.char_code == CH_TAB) begin
            in_kind = K_TAB;
        end else if (i_in_item.char_code == CH_NUL) begin
            in_kind = K_NOP;
        end else begin
            in_kind = K_GLYPH;
        end
    end

    always_comb begin
        o_status.in_kind    = in_kind;
        o_status.col_last   = (r_col == COL_LAST);
        o_status.col_zero   = (r_col == '0);
        o_status.row_zero   = (r_row == '0);
        o_status.row_last   = (r_row == ROW_LAST);
        o_status.is_tab     = is_tab;
        o_status.tab_stop   = (col_inc[TAB_BITS-1:0] == '0);
        o_status.left_space = (r_rd_data[7:0] == CH_SPACE);
        o_status.move_done  = (r_cnt == MOVE_A);
        o_status.cnt_last   = (r_cnt == LAST_A);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // store port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos;
        wr_data = {r_text_color, glyph_ch};
        rd_en   = 1'b0;
        rd_addr = pos - 1'b1;
        if (i_cmd.accept) begin
            rd_en   = in_addr_ok;
            rd_addr = in_addr_ext[AW-1:0];
        end
        unique case (i_cmd.op)
            OP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = BLANK_RESET;
            end
            OP_GLYPH: begin
                wr_en = 1'b1;
            end
            OP_BLANK: begin
                wr_en   = 1'b1;
                wr_data = {r_text_color, CH_SPACE};
            end
            OP_BS_READ: begin
                rd_en = 1'b1;
            end
            OP_SCROLL: begin
                // read one row ahead, write the cell fetched last cycle
                rd_en   = (r_cnt != MOVE_A);
                rd_addr = r_cnt + COLS_A;
                wr_en   = (r_cnt != '0);
                wr_addr = r_cnt - 1'b1;
                wr_data = r_rd_data;
            end
            OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = {r_text_color, CH_SPACE};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_cnt        <= '0;
            r_text_color <= COLOR_RESET;
            r_req_read   <= 1'b0;
            r_addr_ok    <= 1'b0;
            r_scrolled   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_text_color <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_req_read <= i_in_item.req_type;
                r_addr_ok  <= in_addr_ok;
                r_scrolled <= 1'b0;
            end
            case (i_cmd.op)
                OP_INIT, OP_CLEAR: r_cnt <= r_cnt + 1'b1;
                OP_GLYPH: begin
                    r_col <= o_status.col_last ? '0 : col_inc[CW-1:0];
                end
                OP_NEWLINE: begin
                    r_col <= '0;
                    if (o_status.row_last) begin
                        r_scrolled <= 1'b1;
                        r_cnt      <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                OP_SCROLL: begin
                    if (!o_status.move_done) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                OP_BS_START: begin
                    if (!o_status.col_zero) begin
                        r_col <= r_col - 1'b1;
                    end else if (!o_status.row_zero) begin
                        r_row <= r_row - 1'b1;
                        r_col <= COL_LAST;
                    end
                end
                OP_BS_STEP: begin
                    if (o_status.left_space) begin
                        r_col <= r_col - 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in_item.char_code;
        end
        if (i_cmd.load_out) begin
            r_out_item <= out_next;
        end
    end

    always_comb begin
        out_next.cursor_row      = ROW_W'(r_row);
        out_next.cursor_column   = COL_W'(r_col);
        out_next.cursor_position = pos_ext[ADDR_W-1:0];
        out_next.cell_data       = (r_req_read && r_addr_ok) ? r_rd_data : '0;
        out_next.did_scroll      = r_scrolled;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < ROWS) && (int'(r_col) < COLUMNS))
        else $error("cursor outside the screen");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result register loaded while a result is held");

    a_scroll_only_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.did_scroll) |-> (r_out_item.cell_data == '0))
        else $error("scroll flagged on a read result");

endmodule
